[sv/lnw_pkg.sv]
// ----------------------------------------------------------------------------
// lnw_pkg
// Types, codes and microcode for the LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lnw_pkg;

  localparam int LNW_MAX_SHIFT = 16;
  localparam int PC_W          = 3;
  localparam int CNT_W         = 5;
  localparam int IDX_W         = 3;

  // request kinds
  localparam logic [2:0] REQ_CMD    = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_SHIFT  = 3'd3;
  localparam logic [2:0] REQ_INIT   = 3'd4;

  // configuration register indexes
  localparam logic CFG_PULSE  = 1'b0;
  localparam logic CFG_SETTLE = 1'b1;

  // LCD command bytes and init sequence constants
  localparam logic [7:0] LINE0_BASE   = 8'h80;
  localparam logic [7:0] LINE1_BASE   = 8'hC0;
  localparam logic [7:0] SHIFT_LEFT   = 8'h18;
  localparam logic [7:0] SHIFT_RIGHT  = 8'h1C;
  localparam logic [7:0] INIT_TAIL_MS = 8'd5;
  localparam int         INIT_LEN     = 6;

  // microprogram steps
  localparam logic [PC_W-1:0] STEP_HI    = 3'd0;
  localparam logic [PC_W-1:0] STEP_PAUSE = 3'd1;
  localparam logic [PC_W-1:0] STEP_LO    = 3'd2;
  localparam logic [PC_W-1:0] STEP_END   = 3'd3;
  localparam logic [PC_W-1:0] STEP_TAIL  = 3'd4;

  typedef enum logic [1:0] {NIB_HI, NIB_LO, NIB_NONE} nib_sel_t;
  typedef enum logic [1:0] {HOLD_PULSE, HOLD_SETTLE, HOLD_TAIL} hold_sel_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_BYTE_END, JMP_DONE} jmp_t;

  typedef struct packed {
    nib_sel_t  nib;
    logic      en;
    logic      rs;
    hold_sel_t hold;
    jmp_t      jmp;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    unique case (pc)
      STEP_HI:    cw = '{nib: NIB_HI,   en: 1'b1, rs: 1'b1, hold: HOLD_PULSE,
                         jmp: JMP_NEXT};
      STEP_PAUSE: cw = '{nib: NIB_NONE, en: 1'b0, rs: 1'b1, hold: HOLD_SETTLE,
                         jmp: JMP_NEXT};
      STEP_LO:    cw = '{nib: NIB_LO,   en: 1'b1, rs: 1'b1, hold: HOLD_PULSE,
                         jmp: JMP_NEXT};
      STEP_END:   cw = '{nib: NIB_NONE, en: 1'b0, rs: 1'b0, hold: HOLD_SETTLE,
                         jmp: JMP_BYTE_END};
      STEP_TAIL:  cw = '{nib: NIB_NONE, en: 1'b0, rs: 1'b0, hold: HOLD_TAIL,
                         jmp: JMP_DONE};
      default:    cw = '{nib: NIB_NONE, en: 1'b0, rs: 1'b0, hold: HOLD_TAIL,
                         jmp: JMP_DONE};
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h01;
      3'd1:    b = 8'h02;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h06;
      3'd5:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[sv/lcd_nibble_write_sequencer.sv]
// ----------------------------------------------------------------------------
// lcd_nibble_write_sequencer
// Expands one LCD request into timed 8-bit port writes on a 4-bit bus.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the in_* fields with start high; the transaction
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: each port write appears on out_port_value / out_hold_ms /
//   out_last for exactly one cycle with out_strobe high. The receiver cannot
//   stall; one write leaves per cycle while busy is high.
//   Config channel: cfg_ready is always high; cfg_index 0 writes pulse_ms,
//   1 writes settle_ms. Write only while busy is low.
// Timing:
//   The first write appears once busy is set and the output registers
//   load it. A microcode step counter walks four steps per byte
//   (enable-high nibble, pause, enable-high nibble, enable low), one step
//   per cycle. Unused kinds and a zero shift emit nothing.
// Reset:
//   rst_n low clears the sequencer, drops the strobe and restores
//   pulse_ms = 1 and settle_ms = 5.
// ----------------------------------------------------------------------------
module lcd_nibble_write_sequencer
  import lnw_pkg::*;
#(
  parameter int MAX_SHIFT = LNW_MAX_SHIFT
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_byte_value,
  input  logic       in_line_sel,
  input  logic [5:0] in_column,
  input  logic signed [5:0] in_shift_amount,
  // result channel
  output logic       out_strobe,
  output logic [7:0] out_port_value,
  output logic [7:0] out_hold_ms,
  output logic       out_last,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam logic [5:0] MAX_SHIFT_V = 6'(MAX_SHIFT);

  // sequencer state
  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [7:0]      byte_r, byte_nxt;
  logic            is_data_r, is_data_nxt;
  logic            init_r, init_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // config registers
  logic [7:0] pulse_r, settle_r;

  // output registers
  logic       strobe_r, strobe_nxt;
  logic [7:0] port_r, port_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       last_r, last_nxt;

  ctrl_word_t cw;
  logic [3:0] nibble;
  logic       more;
  logic       accept;
  logic [7:0] cursor_addr;
  logic [5:0] shift_mag;
  logic [5:0] shift_cnt;

  assign accept      = start && !busy_r;
  assign cw          = ucode_rom(pc_r);
  assign more        = (cnt_r != '0);
  assign cursor_addr = (in_line_sel ? LINE1_BASE : LINE0_BASE) + {2'b00, in_column};
  // magnitude of the signed shift; -32 maps to 32 in six unsigned bits
  assign shift_mag   = in_shift_amount[5] ? 6'(-in_shift_amount) : in_shift_amount;
  assign shift_cnt   = (shift_mag > MAX_SHIFT_V) ? MAX_SHIFT_V : shift_mag;

  always_comb begin
    unique case (cw.nib)
      NIB_HI:  nibble = byte_r[7:4];
      NIB_LO:  nibble = byte_r[3:0];
      default: nibble = 4'h0;
    endcase
  end

  always_comb begin
    busy_nxt    = busy_r;
    pc_nxt      = pc_r;
    byte_nxt    = byte_r;
    is_data_nxt = is_data_r;
    init_nxt    = init_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    strobe_nxt  = 1'b0;
    port_nxt    = port_r;
    hold_nxt    = hold_r;
    last_nxt    = 1'b0;

    if (busy_r) begin
      // issue the write of the current microcode step
      strobe_nxt = 1'b1;
      port_nxt   = {nibble, cw.en, cw.rs & is_data_r, 2'b00};
      unique case (cw.hold)
        HOLD_PULSE:  hold_nxt = pulse_r;
        HOLD_SETTLE: hold_nxt = settle_r;
        default:     hold_nxt = INIT_TAIL_MS;
      endcase

      unique case (cw.jmp)
        JMP_NEXT: begin
          pc_nxt = pc_r + 1'b1;
        end
        JMP_BYTE_END: begin
          // loop back for another byte, branch to the init tail, or finish
          if (more) begin
            pc_nxt   = STEP_HI;
            cnt_nxt  = cnt_r - 1'b1;
            idx_nxt  = idx_r + 1'b1;
            if (init_r) begin
              byte_nxt = init_cmd(IDX_W'(idx_r + 1'b1));
            end
          end else if (init_r) begin
            pc_nxt = STEP_TAIL;
          end else begin
            busy_nxt = 1'b0;
            last_nxt = 1'b1;
          end
        end
        default: begin
          busy_nxt = 1'b0;
          last_nxt = 1'b1;
        end
      endcase
    end else if (accept) begin
      pc_nxt      = STEP_HI;
      is_data_nxt = 1'b0;
      init_nxt    = 1'b0;
      cnt_nxt     = '0;
      idx_nxt     = '0;
      unique case (in_req_type)
        REQ_CMD: begin
          busy_nxt = 1'b1;
          byte_nxt = in_byte_value;
        end
        REQ_DATA: begin
          busy_nxt    = 1'b1;
          byte_nxt    = in_byte_value;
          is_data_nxt = 1'b1;
        end
        REQ_CURSOR: begin
          busy_nxt = 1'b1;
          byte_nxt = cursor_addr;
        end
        REQ_SHIFT: begin
          // zero shift emits nothing
          busy_nxt = (shift_cnt != '0);
          byte_nxt = in_shift_amount[5] ? SHIFT_LEFT : SHIFT_RIGHT;
          cnt_nxt  = CNT_W'(shift_cnt - 1'b1);
        end
        REQ_INIT: begin
          busy_nxt = 1'b1;
          init_nxt = 1'b1;
          byte_nxt = init_cmd('0);
          cnt_nxt  = CNT_W'(INIT_LEN - 1);
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pc_r      <= STEP_HI;
      is_data_r <= 1'b0;
      init_r    <= 1'b0;
      cnt_r     <= '0;
      idx_r     <= '0;
      strobe_r  <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      pc_r      <= pc_nxt;
      is_data_r <= is_data_nxt;
      init_r    <= init_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      strobe_r  <= strobe_nxt;
      last_r    <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    port_r <= port_nxt;
    hold_r <= hold_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= 8'd1;
      settle_r <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PULSE:  pulse_r  <= cfg_data;
        CFG_SETTLE: settle_r <= cfg_data;
        default:    pulse_r  <= pulse_r;
      endcase
    end
  end

  assign busy           = busy_r;
  assign cfg_ready      = 1'b1;
  assign out_strobe     = strobe_r;
  assign out_port_value = port_r;
  assign out_hold_ms    = hold_r;
  assign out_last       = last_r;

`ifndef SYNTHESIS
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(busy_r))
    else $error("write issued while sequencer idle");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (strobe_r && last_r))
    else $error("sequencer finished without a last write");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && last_r) |=> !strobe_r)
    else $error("write follows last write without a new request");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !strobe_r)
    else $error("write issued in the cycle after acceptance");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= STEP_TAIL))
    else $error("microcode step out of range");
`endif

endmodule

[dv/lcd_write_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_write_tb_pkg
// Request and port-write types plus the port write scoreboard. Each accepted
// request is expanded into the port writes it must produce, and each strobed
// write is checked in order against that list.
// ----------------------------------------------------------------------------
package lcd_write_tb_pkg;
  import lnw_pkg::*;

  localparam logic [7:0]  PORT_EN    = 8'h08;
  localparam logic [7:0]  PORT_RS    = 8'h04;
  localparam logic [47:0] INIT_BYTES = {8'h01, 8'h02, 8'h28, 8'h0C, 8'h06, 8'h80};
  localparam int          INIT_COUNT = 6;

  typedef struct {
    logic [2:0]        kind;
    logic [7:0]        bval;
    logic              line;
    logic [5:0]        col;
    logic signed [5:0] shamt;
  } lcd_request_t;

  typedef struct packed {
    logic [7:0] port;
    logic [7:0] hold;
    logic       last;
  } port_write_t;

  class lcd_write_scoreboard;
    port_write_t expected_writes[$];
    logic [7:0]  pulse_ms;
    logic [7:0]  settle_ms;
    int unsigned n_requests[8];
    int unsigned n_writes;
    int unsigned n_errors;

    function new();
      pulse_ms  = 8'd1;
      settle_ms = 8'd5;
      n_writes  = 0;
      n_errors  = 0;
      foreach (n_requests[i]) n_requests[i] = 0;
    endfunction

    function void write_reg(logic index, logic [7:0] data);
      if (index == CFG_PULSE) pulse_ms = data;
      else settle_ms = data;
    endfunction

    function void queue_write(logic [7:0] port, logic [7:0] hold);
      port_write_t w;
      w.port = port;
      w.hold = hold;
      w.last = 1'b0;
      expected_writes.push_back(w);
    endfunction

    // high nibble, pause, low nibble, enable low; RS holds through the pause
    function void queue_byte(logic [7:0] b, logic is_char);
      logic [7:0] rs;
      rs = is_char ? PORT_RS : 8'h00;
      queue_write({b[7:4], 4'h0} | PORT_EN | rs, pulse_ms);
      queue_write(rs, settle_ms);
      queue_write({b[3:0], 4'h0} | PORT_EN | rs, pulse_ms);
      queue_write(8'h00, settle_ms);
    endfunction

    function void note_request(lcd_request_t r);
      int         amount;
      int         count;
      int         before_n;
      logic [7:0] addr;
      before_n = expected_writes.size();
      n_requests[r.kind]++;
      case (r.kind)
        REQ_CMD:  queue_byte(r.bval, 1'b0);
        REQ_DATA: queue_byte(r.bval, 1'b1);
        REQ_CURSOR: begin
          addr = (r.line ? LINE1_BASE : LINE0_BASE) + {2'b00, r.col};
          queue_byte(addr, 1'b0);
        end
        REQ_SHIFT: begin
          amount = r.shamt;
          count  = (amount < 0) ? -amount : amount;
          if (count > LNW_MAX_SHIFT) count = LNW_MAX_SHIFT;
          for (int i = 0; i < count; i++)
            queue_byte((amount < 0) ? SHIFT_LEFT : SHIFT_RIGHT, 1'b0);
        end
        REQ_INIT: begin
          for (int i = 0; i < INIT_COUNT; i++)
            queue_byte(INIT_BYTES[47 - 8 * i -: 8], 1'b0);
          queue_write(8'h00, INIT_TAIL_MS);
        end
        default: ;
      endcase
      if (expected_writes.size() > before_n)
        expected_writes[expected_writes.size() - 1].last = 1'b1;
    endfunction

    function void check_write(logic [7:0] port, logic [7:0] hold, logic last);
      port_write_t exp;
      if (expected_writes.size() == 0) begin
        $display("%0t: unexpected port write port_value=%h hold_ms=%h last=%b",
                 $time, port, hold, last);
        n_errors++;
        return;
      end
      exp = expected_writes.pop_front();
      n_writes++;
      if (port !== exp.port) begin
        $display("%0t: port_value expected %h, actual %h", $time, exp.port, port);
        n_errors++;
      end
      if (hold !== exp.hold) begin
        $display("%0t: hold_ms expected %h, actual %h", $time, exp.hold, hold);
        n_errors++;
      end
      if (last !== exp.last) begin
        $display("%0t: last expected %b, actual %b", $time, exp.last, last);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Request-level test of the LCD nibble write sequencer. Directed requests
// cover byte extremes, every request kind, cursor columns past the visible
// range, zero and saturating shifts and the init sequence; weighted random
// requests follow under several pulse/settle settings. Requests are offered
// with random gaps and every strobed port write is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lnw_pkg::*;
  import lcd_write_tb_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        in_req_type = REQ_CMD;
  logic [7:0]        in_byte_value = 8'h00;
  logic              in_line_sel = 1'b0;
  logic [5:0]        in_column = 6'd0;
  logic signed [5:0] in_shift_amount = 6'sd0;
  logic              out_strobe;
  logic [7:0]        out_port_value;
  logic [7:0]        out_hold_ms;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_PULSE;
  logic [7:0]        cfg_data = 8'h00;

  // when set, requests go back to back with no idle cycles in between
  logic              no_gaps = 1'b0;
  int unsigned       n_settings = 1;

  lcd_write_scoreboard sb = new();

  lcd_nibble_write_sequencer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_byte_value   (in_byte_value),
    .in_line_sel     (in_line_sel),
    .in_column       (in_column),
    .in_shift_amount (in_shift_amount),
    .out_strobe      (out_strobe),
    .out_port_value  (out_port_value),
    .out_hold_ms     (out_hold_ms),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample every handshake on the pre-edge values. Check the strobed write
  // first so a request taken on the same edge queues behind older writes.
  always @(posedge clk) begin
    lcd_request_t seen;
    if (rst_n) begin
      if (out_strobe === 1'b1)
        sb.check_write(out_port_value, out_hold_ms, out_last);
      if (cfg_valid && cfg_ready === 1'b1)
        sb.write_reg(cfg_index, cfg_data);
      if (start && busy === 1'b0) begin
        seen.kind  = in_req_type;
        seen.bval  = in_byte_value;
        seen.line  = in_line_sel;
        seen.col   = in_column;
        seen.shamt = in_shift_amount;
        sb.note_request(seen);
      end
    end
  end

  function automatic lcd_request_t make_request(logic [2:0] kind, logic [7:0] bval,
                                                logic line, logic [5:0] col,
                                                logic signed [5:0] shamt);
    lcd_request_t r;
    r.kind  = kind;
    r.bval  = bval;
    r.line  = line;
    r.col   = col;
    r.shamt = shamt;
    return r;
  endfunction

  // Mostly well-formed kinds; fields the kind does not use stay random.
  function automatic lcd_request_t random_request();
    lcd_request_t r;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)      r.kind = REQ_CMD;
    else if (pick < 50) r.kind = REQ_DATA;
    else if (pick < 65) r.kind = REQ_CURSOR;
    else if (pick < 85) r.kind = REQ_SHIFT;
    else if (pick < 90) r.kind = REQ_INIT;
    else                r.kind = 3'($urandom_range(int'(REQ_INIT) + 1, 7));
    r.bval = 8'($urandom);
    r.line = 1'($urandom);
    if ($urandom_range(0, 9) == 0) r.col = 6'($urandom_range(40, 63));
    else                           r.col = 6'($urandom_range(0, 39));
    // keep most shifts short so the run stays fast; some hit saturation
    if ($urandom_range(0, 4) == 0) r.shamt = 6'($urandom);
    else                           r.shamt = 6'(int'($urandom_range(0, 8)) - 4);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request, hold it until taken, then idle for a random gap.
  // Leave start high across a zero gap so it is never dropped and raised in
  // the same step.
  task automatic send_request(input lcd_request_t r);
    int unsigned gap;
    start           <= 1'b1;
    in_req_type     <= r.kind;
    in_byte_value   <= r.bval;
    in_line_sel     <= r.line;
    in_column       <= r.col;
    in_shift_amount <= r.shamt;
    do @(posedge clk); while (busy !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected write is out and the block is
  // idle; give it a few more cycles for requests that emit nothing.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write pulse_ms then settle_ms as two back-to-back transactions.
  task automatic program_timing(input logic [7:0] pulse, input logic [7:0] settle);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_PULSE;
    cfg_data  <= pulse;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_index <= CFG_SETTLE;
    cfg_data  <= settle;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  initial begin
    logic [7:0] pulse_set[6];
    logic [7:0] settle_set[6];
    pulse_set  = '{8'd0, 8'd255, 8'd0,   8'd255, 8'd0, 8'd0};
    settle_set = '{8'd0, 8'd255, 8'd255, 8'd0,   8'd0, 8'd0};
    // last two settings are random
    pulse_set[4]  = 8'($urandom);
    settle_set[4] = 8'($urandom);
    pulse_set[5]  = 8'($urandom);
    settle_set[5] = 8'($urandom);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset timing values.
    send_request(make_request(REQ_CMD,    8'h00, 1'b0, 6'd0,  6'sd0));
    send_request(make_request(REQ_CMD,    8'hFF, 1'b1, 6'd63, -6'sd1));
    send_request(make_request(REQ_CMD,    8'h5A, 1'b0, 6'd21, 6'sd9));
    send_request(make_request(REQ_DATA,   8'h00, 1'b1, 6'd5,  6'sd3));
    send_request(make_request(REQ_DATA,   8'hFF, 1'b0, 6'd0,  6'sd0));
    send_request(make_request(REQ_DATA,   8'hA5, 1'b1, 6'd42, -6'sd32));
    send_request(make_request(REQ_CURSOR, 8'hFF, 1'b0, 6'd0,  6'sd0));
    send_request(make_request(REQ_CURSOR, 8'h00, 1'b1, 6'd39, 6'sd0));
    send_request(make_request(REQ_CURSOR, 8'h00, 1'b1, 6'd63, 6'sd0));
    send_request(make_request(REQ_CURSOR, 8'h00, 1'b0, 6'd63, 6'sd0));
    // zero, unit, full-range and saturating shifts both ways
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  6'sd0));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  6'sd1));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  -6'sd1));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  6'sd16));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  -6'sd16));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  6'sd31));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  -6'sd32));
    send_request(make_request(REQ_SHIFT,  8'h00, 1'b0, 6'd0,  6'sd17));
    send_request(make_request(REQ_INIT,   8'hFF, 1'b1, 6'd63, 6'sd31));
    for (int k = int'(REQ_INIT) + 1; k < 8; k++)
      send_request(make_request(3'(k), 8'($urandom), 1'($urandom), 6'($urandom),
                                6'($urandom)));
    send_request(make_request(REQ_CMD,    8'h01, 1'b0, 6'd0,  6'sd0));

    // Random part: retime only when idle, then run a batch per setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      program_timing(pulse_set[ph], settle_set[ph]);
      for (int i = 0; i < 73; i++) begin
        // switch between gapped and back-to-back stretches now and then
        if ($urandom_range(0, 24) == 0) no_gaps <= ~no_gaps;
        send_request(random_request());
      end
    end

    drain();
    $display("Run covered %0d cmd, %0d data, %0d cursor, %0d shift, %0d init requests",
             sb.n_requests[REQ_CMD], sb.n_requests[REQ_DATA], sb.n_requests[REQ_CURSOR],
             sb.n_requests[REQ_SHIFT], sb.n_requests[REQ_INIT]);
    $display("plus %0d unused kinds; %0d port writes checked over %0d timing settings",
             sb.n_requests[5] + sb.n_requests[6] + sb.n_requests[7], sb.n_writes,
             n_settings);
    if (sb.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
